FILE: rtl/lkc_pkg.sv
// Shared types and constants for the LRU keyed cache.
`default_nettype none
package lkc_pkg;

    localparam int LKC_ENTRIES = 16;
    localparam int CFG_W       = 5;
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;
    localparam int KIND_W      = 2;
    localparam logic [CFG_W-1:0] CACHE_SIZE_RST = CFG_W'(16);

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  hit;
    } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/lkc_cell.sv
// One recency slot of the cache: holds a key and value, shifts with its neighbors.
`default_nettype none
module lkc_cell
    import lkc_pkg::*;
#(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
)
(
    input  wire logic             clk,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [CNT_W-1:0] cnt,
    input  wire logic [KEY_W-1:0] key_req,
    input  wire logic [KEY_W-1:0] left_key,
    input  wire logic [VAL_W-1:0] left_val,
    input  wire logic [KEY_W-1:0] right_key,
    input  wire logic [VAL_W-1:0] right_val,
    input  wire logic             seen_in,
    output logic                  seen_out,
    input  wire logic [VAL_W-1:0] hitv_in,
    output logic [VAL_W-1:0]      hitv_out,
    output logic [KEY_W-1:0]      key_q,
    output logic [VAL_W-1:0]      val_q
);

    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic             valid;
    logic             match;

    assign valid    = (CNT_W'(IDX) < cnt);
    assign match    = valid && (key_reg == key_req);
    assign seen_out = seen_in | match;
    assign hitv_out = match ? val_reg : hitv_in;
    assign key_q    = key_reg;
    assign val_q    = val_reg;

    always_comb
    begin
        key_next = key_reg;
        val_next = val_reg;
        case (ctrl.kind)
            KIND_LOOKUP:
            begin
                if (ctrl.hit && !seen_in)
                begin
                    key_next = left_key;
                    val_next = left_val;
                end
            end
            KIND_INSERT:
            begin
                if (!ctrl.hit)
                begin
                    key_next = left_key;
                    val_next = left_val;
                end
            end
            KIND_DELETE:
            begin
                if (ctrl.hit && seen_out)
                begin
                    key_next = right_key;
                    val_next = right_val;
                end
            end
            default:
            begin
                key_next = key_reg;
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        val_reg <= val_next;
    end

endmodule
`default_nettype wire

FILE: rtl/lru_keyed_cache.sv
// Fully associative LRU cache of 64-bit keys built as a row of recency-ordered cells.
//
// Input stream s_axis: tdata carries key (bits 63:0) and value_in (bits 127:64),
// tuser carries the operation kind (0 lookup, 1 insert, 2 delete, 3 no-op).
// Output stream m_axis: one word per input word; tdata is value_out, tuser holds
// found (bit 0) and evicted (bit 1).
// Cells are kept in recency order, most recent at cell 0; every operation compares
// all cells in parallel and moves the affected cells one step toward their
// neighbor in the same cycle. An item is taken every cycle unless the receiver stalls;
// its result is registered and visible in the cycle after acceptance. The compare,
// prefix and shift path through the row of CACHE_ENTRIES cells sets the cycle.
// When the receiver stalls, the result stays in the output register and one more
// word is refused until that result is taken.
// cfg_we/cfg_wdata write cache_size; write only while the block is idle.
// Reset empties the cache (occupancy zero) and sets cache_size to 16; the
// block accepts words as soon as reset is released.
`default_nettype none
module lru_keyed_cache
    import lkc_pkg::*;
#(
    parameter int CACHE_ENTRIES = LKC_ENTRIES
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [KEY_W+VAL_W-1:0] s_axis_tdata,  // key, value_in
    input  wire logic [KIND_W-1:0]      s_axis_tuser,  // kind
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [VAL_W-1:0]            m_axis_tdata,  // value_out
    output logic [1:0]                  m_axis_tuser,  // found, evicted
    input  wire logic                   cfg_we,
    input  wire logic [CFG_W-1:0]       cfg_wdata
);

    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0] cache_size_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg;
    logic             found_reg, evicted_reg;
    logic [VAL_W-1:0] value_reg;

    logic [KEY_W-1:0] key_req;
    logic [VAL_W-1:0] value_in;
    kind_t            kind;
    logic             accept;
    logic             hit;
    logic             do_evict;
    logic [LIM_W-1:0] limit;
    logic [LIM_W-1:0] size_ext;
    cell_ctrl_t       ctrl;
    logic             found_next, evicted_next;
    logic [VAL_W-1:0] value_next;
    logic [VAL_W-1:0] inj_val;

    logic [KEY_W-1:0] cell_key [CACHE_ENTRIES];
    logic [VAL_W-1:0] cell_val [CACHE_ENTRIES];
    logic             seen     [CACHE_ENTRIES+1];
    logic [VAL_W-1:0] hitv     [CACHE_ENTRIES+1];

    assign key_req  = s_axis_tdata[KEY_W-1:0];
    assign value_in = s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
    assign kind     = kind_t'(s_axis_tuser);

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = value_reg;
    assign m_axis_tuser  = {evicted_reg, found_reg};

    assign seen[0]             = 1'b0;
    assign hitv[CACHE_ENTRIES] = '0;
    assign hit                 = seen[CACHE_ENTRIES];

    assign ctrl.kind = accept ? kind : KIND_NOP;
    assign ctrl.hit  = hit;

    assign inj_val = (kind == KIND_INSERT) ? value_in : hitv[0];

    genvar gi;
    generate
        for (gi = 0; gi < CACHE_ENTRIES; gi++)
        begin : g_cell
            logic [KEY_W-1:0] lk, rk;
            logic [VAL_W-1:0] lv, rv;
            if (gi == 0)
            begin : g_head
                assign lk = key_req;
                assign lv = inj_val;
            end
            else
            begin : g_body
                assign lk = cell_key[gi-1];
                assign lv = cell_val[gi-1];
            end
            if (gi == CACHE_ENTRIES - 1)
            begin : g_tail
                assign rk = '0;
                assign rv = '0;
            end
            else
            begin : g_inner
                assign rk = cell_key[gi+1];
                assign rv = cell_val[gi+1];
            end
            lkc_cell #(
                .CNT_W (CNT_W),
                .IDX   (gi)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .cnt       (count_reg),
                .key_req   (key_req),
                .left_key  (lk),
                .left_val  (lv),
                .right_key (rk),
                .right_val (rv),
                .seen_in   (seen[gi]),
                .seen_out  (seen[gi+1]),
                .hitv_in   (hitv[gi+1]),
                .hitv_out  (hitv[gi]),
                .key_q     (cell_key[gi]),
                .val_q     (cell_val[gi])
            );
        end
    endgenerate

    always_comb
    begin
        size_ext = LIM_W'(cache_size_reg);
        if (size_ext == '0)
            limit = LIM_W'(1);
        else if (size_ext > LIM_W'(CACHE_ENTRIES))
            limit = LIM_W'(CACHE_ENTRIES);
        else
            limit = size_ext;
    end

    assign do_evict = (LIM_W'(count_reg) >= limit);

    always_comb
    begin
        count_next   = count_reg;
        found_next   = 1'b0;
        evicted_next = 1'b0;
        value_next   = '0;
        case (kind)
            KIND_LOOKUP:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    value_next = hitv[0];
                end
            end
            KIND_INSERT:
            begin
                if (!hit)
                begin
                    found_next = 1'b1;
                    if (do_evict)
                        evicted_next = 1'b1;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_DELETE:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_size_reg <= CACHE_SIZE_RST;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            evicted_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cache_size_reg <= cfg_wdata;
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
                found_reg     <= found_next;
                evicted_reg   <= evicted_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            value_reg <= value_next;
    end

endmodule
`default_nettype wire

FILE: rtl/lkc_checker.sv
// Port-level checks for the LRU keyed cache, bound to the top level.
`default_nettype none
module lkc_checker
    import lkc_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [VAL_W-1:0]       m_axis_tdata,
    input wire logic [1:0]             m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    a_evict_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0] && (m_axis_tdata == '0))
        else $error("eviction without accepted insert");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tuser[1])
        else $error("nonzero result on refused or missed word");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register empty");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted word produced no result");

endmodule

bind lru_keyed_cache lkc_checker u_lkc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

FILE: tb/sv/lkc_checker.sv
// Checker for the LRU keyed cache: predicts each answer and compares the output stream.
module lkc_tb_checker
    import lkc_pkg::*;
#(
    parameter int ENTRIES = LKC_ENTRIES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [KEY_W+VAL_W-1:0] s_axis_tdata,  // key, value_in
    input  logic [KIND_W-1:0]      s_axis_tuser,  // kind
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [VAL_W-1:0]       m_axis_tdata,  // value_out
    input  logic [1:0]             m_axis_tuser,  // found, evicted
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_wdata,
    output int                     fails,
    output int                     pending
);

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] value;
        logic             evicted;
    } cache_answer_t;

    logic [KEY_W-1:0]  slot_key  [ENTRIES];
    logic [VAL_W-1:0]  slot_val  [ENTRIES];
    logic              slot_used [ENTRIES];
    logic [RANK_W-1:0] slot_rank [ENTRIES];
    logic [CNT_W-1:0]  occupancy;
    logic [CFG_W-1:0]  size_reg;
    cache_answer_t     pending_answers [$];
    int                errors = 0;

    function automatic int find_slot(input logic [KEY_W-1:0] key);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int size_limit();
        if (size_reg == '0)
            return 1;
        if (int'(size_reg) > ENTRIES)
            return ENTRIES;
        return int'(size_reg);
    endfunction

    // close the rank gap left by the removed slot
    function automatic void remove_slot(input int s);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_rank[i] > slot_rank[s])
                slot_rank[i] = slot_rank[i] - 1'b1;
        slot_used[s] = 1'b0;
        slot_rank[s] = '0;
        if (occupancy != '0)
            occupancy = occupancy - 1'b1;
    endfunction

    function automatic cache_answer_t cache_apply(input logic [KIND_W-1:0] op,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [VAL_W-1:0] val);
        cache_answer_t ans;
        int s;
        int victim;
        ans = '0;
        case (op)
            KIND_LOOKUP:
            begin
                s = find_slot(key);
                if (s >= 0)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot_used[i] && slot_rank[i] < slot_rank[s])
                            slot_rank[i] = slot_rank[i] + 1'b1;
                    slot_rank[s] = '0;
                    ans.found = 1'b1;
                    ans.value = slot_val[s];
                end
            end
            KIND_INSERT:
            begin
                if (find_slot(key) < 0)
                begin
                    if (int'(occupancy) >= size_limit())
                    begin
                        victim = -1;
                        for (int i = 0; i < ENTRIES; i++)
                            if (slot_used[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
                                victim = i;
                        if (victim >= 0)
                        begin
                            remove_slot(victim);
                            ans.evicted = 1'b1;
                        end
                    end
                    s = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (s < 0 && !slot_used[i])
                            s = i;
                    if (s >= 0)
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (slot_used[i])
                                slot_rank[i] = slot_rank[i] + 1'b1;
                        slot_key[s]  = key;
                        slot_val[s]  = val;
                        slot_used[s] = 1'b1;
                        slot_rank[s] = '0;
                        occupancy    = occupancy + 1'b1;
                        ans.found    = 1'b1;
                    end
                end
            end
            KIND_DELETE:
            begin
                s = find_slot(key);
                if (s >= 0)
                begin
                    remove_slot(s);
                    ans.found = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cache_answer_t want;
        cache_answer_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_used[i] = 1'b0;
                slot_rank[i] = '0;
            end
            occupancy = '0;
            size_reg  = CACHE_SIZE_RST;
            pending_answers.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                size_reg = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                pending_answers.push_back(cache_apply(s_axis_tuser,
                                                      s_axis_tdata[KEY_W-1:0],
                                                      s_axis_tdata[KEY_W +: VAL_W]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.found   = m_axis_tuser[0];
                got.value   = m_axis_tdata;
                got.evicted = m_axis_tuser[1];
                if (pending_answers.size() == 0)
                begin
                    $display("%0t: unexpected word found=%b value_out=%h evicted=%b",
                             $time, got.found, got.value, got.evicted);
                    errors++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (got.found !== want.found)
                    begin
                        $display("%0t: found expected %b actual %b",
                                 $time, want.found, got.found);
                        errors++;
                    end
                    if (got.value !== want.value)
                    begin
                        $display("%0t: value_out expected %h actual %h",
                                 $time, want.value, got.value);
                        errors++;
                    end
                    if (got.evicted !== want.evicted)
                    begin
                        $display("%0t: evicted expected %b actual %b",
                                 $time, want.evicted, got.evicted);
                        errors++;
                    end
                end
            end
            pending <= pending_answers.size();
        end
        fails <= errors;
    end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the LRU keyed cache testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_top
    import lkc_pkg::*;
();

    localparam int POOL_N      = 20;
    localparam int PHASE_N     = 7;
    localparam int PHASE_ITEMS = 58;
    localparam int FLOOD_ITEMS = 24;
    localparam int HOLD_CYCLES = 60;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [KEY_W+VAL_W-1:0] s_axis_tdata;  // key, value_in
    logic [KIND_W-1:0]      s_axis_tuser;  // kind
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [VAL_W-1:0]       m_axis_tdata;  // value_out
    logic [1:0]             m_axis_tuser;  // found, evicted
    logic                   cfg_we;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   flood;
    int                     fails;
    int                     pending;

    logic [KEY_W-1:0] key_pool [POOL_N];
    logic [KEY_W-1:0] recent_keys [4];
    int               recent_pos;
    logic [CFG_W-1:0] phase_size [PHASE_N] = '{5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd16, 5'd9};

    always #4 clk = ~clk;

    lru_keyed_cache dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    lkc_tb_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fails         (fails),
        .pending       (pending)
    );

    initial
    begin
        #(2_000_000);
        $display("== FAIL ==");
        $finish;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 0;
        if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 25);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic send_word(input logic [KIND_W-1:0] op, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] val, input int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {val, key};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(input int gap);
        int r;
        logic [KIND_W-1:0] op;
        logic [KEY_W-1:0] key;
        r = $urandom_range(0, 19);
        op = (r < 8) ? KIND_LOOKUP : (r < 15) ? KIND_INSERT : (r < 19) ? KIND_DELETE : KIND_NOP;
        if (op == KIND_LOOKUP && $urandom_range(0, 1) == 1)
            key = recent_keys[$urandom_range(0, 3)];
        else if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, POOL_N - 1)];
        else
            key = {$urandom, $urandom};
        if (op == KIND_INSERT)
        begin
            recent_keys[recent_pos] = key;
            recent_pos = (recent_pos + 1) % 4;
        end
        send_word(op, key, pick_value(), gap);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: random ready stretches, one long hold-off per flood burst
    initial
    begin
        int left;
        logic rdy;
        logic held;
        int gap;
        m_axis_tready = 1'b0;
        left = 0;
        rdy  = 1'b0;
        held = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (flood && !held)
            begin
                held = 1'b1;
                rdy  = 1'b0;
                left = HOLD_CYCLES;
            end
            else if (left <= 0)
            begin
                if (rdy)
                begin
                    gap = idle_gap();
                    if (gap > 0)
                    begin
                        rdy  = 1'b0;
                        left = gap;
                    end
                    else
                        left = $urandom_range(1, 12);
                end
                else
                begin
                    rdy  = 1'b1;
                    left = $urandom_range(1, 12);
                end
            end
            if (!flood)
                held = 1'b0;
            m_axis_tready <= rdy;
            @(posedge clk);
            left--;
        end
    end

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_LOOKUP;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        flood         = 1'b0;
        recent_pos    = 0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_N; i++)
            key_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < 4; i++)
            recent_keys[i] = key_pool[i];

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty cache, unused kind, refused insert, hits, a delete hit and delete misses
        send_word(KIND_LOOKUP, key_pool[0], '1, idle_gap());
        send_word(KIND_DELETE, key_pool[1], '1, idle_gap());
        send_word(KIND_NOP, '1, '1, idle_gap());
        send_word(KIND_INSERT, key_pool[0], '1, idle_gap());
        send_word(KIND_INSERT, key_pool[1], '0, idle_gap());
        send_word(KIND_INSERT, key_pool[0], '0, idle_gap());
        send_word(KIND_LOOKUP, key_pool[0], '0, idle_gap());
        send_word(KIND_LOOKUP, key_pool[1], '1, idle_gap());
        send_word(KIND_DELETE, key_pool[1], '0, idle_gap());
        send_word(KIND_DELETE, key_pool[1], '0, idle_gap());
        // fill to the reset limit, then evict
        for (int i = 2; i <= 17; i++)
            send_word(KIND_INSERT, key_pool[i], {$urandom, $urandom}, idle_gap());

        for (int ph = 0; ph < PHASE_N; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                write_size(phase_size[ph]);
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == 8 && (ph == 1 || ph == 5))
                begin
                    flood <= 1'b1;
                    repeat (FLOOD_ITEMS) send_random(0);
                    flood <= 1'b0;
                end
                if (i == 30 && ph == 3)
                    drain();
                send_random(idle_gap());
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
